@@ design/u8dfa_pkg.sv @@
// Constants and lookup functions for the UTF-8 byte decoder.
// Holds the byte class map, the DFA transition table and the result codes.
// No dependencies.
package u8dfa_pkg;

	localparam int unsigned STATE_W = 4;
	localparam int unsigned CLASS_W = 4;
	localparam int unsigned CODE_W  = 21;
	localparam int unsigned KIND_W  = 2;

	localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
	localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
	localparam logic [STATE_W-1:0] ST_COUNT  = 4'd9;

	localparam logic [KIND_W-1:0] KIND_PENDING = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

	localparam logic [7:0] LEAD_MASK = 8'hff;

	localparam logic [STATE_W-1:0] NEXT_STATE_TABLE [0:143] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
		4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
		4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
	};

	function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
		logic [CLASS_W-1:0] cls;
		case (b) inside
			[8'h00:8'h7f]: cls = 4'd0;
			[8'h80:8'h8f]: cls = 4'd1;
			[8'h90:8'h9f]: cls = 4'd9;
			[8'ha0:8'hbf]: cls = 4'd7;
			[8'hc0:8'hc1]: cls = 4'd8;
			[8'hc2:8'hdf]: cls = 4'd2;
			8'he0:         cls = 4'd10;
			[8'he1:8'hec]: cls = 4'd3;
			8'hed:         cls = 4'd4;
			[8'hee:8'hef]: cls = 4'd3;
			8'hf0:         cls = 4'd11;
			[8'hf1:8'hf3]: cls = 4'd6;
			8'hf4:         cls = 4'd5;
			default:       cls = 4'd8;
		endcase
		return cls;
	endfunction

	function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] cur,
		input logic [CLASS_W-1:0] cls);
		return NEXT_STATE_TABLE[{cur, cls}];
	endfunction

endpackage

@@ design/u8dfa_stream_if.sv @@
// Valid/ready channel interfaces for the UTF-8 byte decoder.
// One interface for the byte stream and one for decoded results; uses u8dfa_pkg.
interface u8dfa_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface u8dfa_result_if;
	logic                          valid;
	logic                          ready;
	logic [u8dfa_pkg::KIND_W-1:0]  result_kind;
	logic [u8dfa_pkg::CODE_W-1:0]  code_point;

	modport source (output valid, output result_kind, output code_point, input ready);
	modport sink (input valid, input result_kind, input code_point, output ready);
endinterface

@@ design/utf8_dfa_decoder.sv @@
// Top level of the strict UTF-8 decoder: one byte in, one result out.
// Depends on u8dfa_pkg and the channel interfaces in u8dfa_stream_if.sv.
//
// channel   role   payload                      per item
// bytes     sink   data_byte[7:0]               one raw byte
// results   source result_kind[1:0], code_point one result per byte
//
// Each byte is decoded in the cycle it is accepted and its result is held in
// an output register, so one byte per cycle is sustained while results are
// taken. The limit is the class lookup, table lookup and shift path.
// Reset puts the decoder in the accepting state with an empty output register.
// A stall on results holds the output register and blocks new bytes only
// while that register is full and not being taken.
module utf8_dfa_decoder (
	input logic               clk,
	input logic               arst_n,
	u8dfa_byte_if.sink        bytes,
	u8dfa_result_if.source    results
);
	import u8dfa_pkg::*;

	logic [STATE_W-1:0] dfa_state_q;
	logic [CODE_W-1:0]  partial_code_q;
	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [CODE_W-1:0]  out_code_q;

	logic               accept;
	logic [CLASS_W-1:0] cls;
	logic               dead;
	logic [STATE_W-1:0] state_d;
	logic [CODE_W-1:0]  partial_d;
	logic [KIND_W-1:0]  kind_d;
	logic [CODE_W-1:0]  code_d;

	assign bytes.ready = !out_valid_q || results.ready;
	assign accept      = bytes.valid && bytes.ready;

	always_comb begin
		cls       = byte_class(bytes.data_byte);
		dead      = (dfa_state_q >= ST_COUNT) || (dfa_state_q == ST_REJECT);
		partial_d = partial_code_q;
		state_d   = ST_REJECT;
		kind_d    = KIND_ERROR;
		code_d    = '0;
		if (!dead) begin
			if (dfa_state_q != ST_ACCEPT) begin
				partial_d = {partial_code_q[CODE_W-7:0], bytes.data_byte[5:0]};
			end else begin
				partial_d = {{(CODE_W-8){1'b0}}, (LEAD_MASK >> cls) & bytes.data_byte};
			end
			state_d = next_state(dfa_state_q, cls);
			if (state_d == ST_ACCEPT) begin
				kind_d = KIND_DONE;
				code_d = partial_d;
			end else if (state_d != ST_REJECT) begin
				kind_d = KIND_PENDING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dfa_state_q    <= ST_ACCEPT;
			partial_code_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				dfa_state_q    <= state_d;
				partial_code_q <= partial_d;
				out_valid_q    <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_kind_q <= kind_d;
			out_code_q <= code_d;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.result_kind = out_kind_q;
	assign results.code_point  = out_code_q;

	a_reject_absorbs: assert property (@(posedge clk) disable iff (!arst_n)
		dfa_state_q == ST_REJECT |=> dfa_state_q == ST_REJECT)
		else $error("decoder left the reject state");

	a_accept_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_code_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != KIND_DONE |-> out_code_q == '0)
		else $error("code point set on a result that is not complete");

	a_code_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_DONE |->
			out_code_q <= 21'h10ffff && !(out_code_q >= 21'hd800 && out_code_q <= 21'hdfff))
		else $error("completed code point outside the valid scalar range");

endmodule
